>>> hw/rtl/palette_layer_compositor_unit_defines.svh
// ----------------------------------------------------------------------------
// palette layer compositor assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous rst_n
// ----------------------------------------------------------------------------
`ifndef PALETTE_LAYER_COMPOSITOR_UNIT_DEFINES_SVH
`define PALETTE_LAYER_COMPOSITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// types, constants and helpers of the palette layer compositor
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int PAL_DEPTH  = 256;
  localparam int MAX_LAYERS = 4;
  localparam int LAYER_FIELDS = 4;

  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam int PAL_IDX_W  = 8;
  localparam int PAL_CH_W   = 8;
  localparam int PAL_RGB_W  = 3 * PAL_CH_W;
  localparam int PAL_LC_W   = 3;

  // free-entry search: groups of PAL_GW flags, at most PAL_GW groups
  localparam int PAL_GW     = 16;
  localparam int PAL_SW     = $clog2(PAL_GW);
  localparam int PAL_NG     = (PAL_DEPTH + PAL_GW - 1) / PAL_GW;
  localparam int PAL_PAD_W  = PAL_GW * PAL_GW;

  localparam int PAL_LAYER_LIM = (MAX_LAYERS < LAYER_FIELDS) ? MAX_LAYERS : LAYER_FIELDS;

  typedef enum logic [1:0] {
    ACT_UPDATE  = 2'd0,
    ACT_CREATE  = 2'd1,
    ACT_RESET   = 2'd2,
    ACT_CONVERT = 2'd3
  } plc_action_t;

  typedef struct packed {
    plc_action_t           action;
    logic [PAL_IDX_W-1:0]  entry_index;
    logic [PAL_CH_W-1:0]   red;
    logic [PAL_CH_W-1:0]   green;
    logic [PAL_CH_W-1:0]   blue;
    logic [PAL_IDX_W-1:0]  layer0_index;
    logic [PAL_IDX_W-1:0]  layer1_index;
    logic [PAL_IDX_W-1:0]  layer2_index;
    logic [PAL_IDX_W-1:0]  layer3_index;
  } plc_in_t;

  typedef struct packed {
    logic [PAL_IDX_W-1:0]  pen_index;
    logic                  no_free_entry;
    logic [PAL_RGB_W-1:0]  rgb_pixel;
  } plc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_FIND,
    S_ALLOC,
    S_RESULT
  } plc_state_t;

  typedef struct packed {
    logic latch;
    logic write_entry;
    logic read_entry;
    logic find_group;
    logic alloc_entry;
    logic load_out;
  } plc_cmd_t;

  typedef struct packed {
    logic              found;
    logic [PAL_SW-1:0] idx;
  } plc_pick_t;

  // lowest clear bit of a flag group
  function automatic plc_pick_t plc_first_zero(logic [PAL_GW-1:0] v);
    plc_pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = PAL_GW - 1; i >= 0; i--) begin
      if (!v[i]) begin
        p.found = 1'b1;
        p.idx   = PAL_SW'(i);
      end
    end
    return p;
  endfunction

endpackage

>>> hw/rtl/plc_datapath.sv
// ----------------------------------------------------------------------------
// plc_datapath
// palette memory, used flags, free-entry search, layer pick, result register
// ----------------------------------------------------------------------------
module plc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  plc_pkg::plc_in_t            in_data,
  input  logic                        cfg_we,
  input  logic [plc_pkg::PAL_LC_W-1:0] cfg_data,
  input  plc_pkg::plc_cmd_t           cmd,
  output plc_pkg::plc_out_t           out_data
);
  import plc_pkg::*;

  typedef struct packed {
    plc_action_t          action;
    logic [PAL_IDX_W-1:0] entry_index;
    logic [PAL_RGB_W-1:0] color;
  } plc_item_t;

  logic [PAL_RGB_W-1:0] mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] used_r;
  logic [PAL_DEPTH-1:0] written_r;
  logic [PAL_LC_W-1:0]  layer_count_r;

  plc_item_t            item_r;
  logic [PAL_IDX_W-1:0] pick_r;
  logic                 pick_ok_r;
  logic [PAL_RGB_W-1:0] rd_data_r;
  logic                 rd_written_r;
  logic [PAL_SW-1:0]    grp_r;
  logic                 grp_found_r;
  logic [PAL_IDX_W-1:0] pen_r;
  logic                 fail_r;
  plc_out_t             out_r;

  logic [PAL_IDX_W-1:0] layers [LAYER_FIELDS];
  logic [PAL_LC_W-1:0]  n_active;
  logic [PAL_IDX_W-1:0] pick_nxt;
  logic                 pick_ok_nxt;

  logic [PAL_PAD_W-1:0] used_pad;
  logic [PAL_GW-1:0]    grp_full;
  logic [PAL_GW-1:0]    grp_sel;
  plc_pick_t            grp_pick;
  plc_pick_t            slot_pick;
  logic [2*PAL_SW-1:0]  alloc_idx;

  logic                 item_ok;
  logic                 wr_en;
  logic                 wr_used;
  logic [PAL_AW-1:0]    wr_addr;
  logic [PAL_RGB_W-1:0] wr_data;
  plc_out_t             out_nxt;

  // top enabled nonzero layer wins
  always_comb begin
    layers[0] = in_data.layer0_index;
    layers[1] = in_data.layer1_index;
    layers[2] = in_data.layer2_index;
    layers[3] = in_data.layer3_index;
    if (layer_count_r == '0) begin
      n_active = PAL_LC_W'(1);
    end else if (layer_count_r > PAL_LC_W'(PAL_LAYER_LIM)) begin
      n_active = PAL_LC_W'(PAL_LAYER_LIM);
    end else begin
      n_active = layer_count_r;
    end
    pick_nxt = '0;
    for (int k = 0; k < LAYER_FIELDS; k++) begin
      if ((PAL_LC_W'(k) < n_active) && (layers[k] != '0)) begin
        pick_nxt = layers[k];
      end
    end
    pick_ok_nxt = ({1'b0, pick_nxt} < (PAL_IDX_W + 1)'(PAL_DEPTH));
  end

  // free-entry search, group level then slot level
  always_comb begin
    used_pad = '1;
    used_pad[PAL_DEPTH-1:0] = used_r;
    grp_full = '1;
    for (int g = 0; g < PAL_NG; g++) begin
      grp_full[g] = &used_pad[g*PAL_GW +: PAL_GW];
    end
    grp_pick  = plc_first_zero(grp_full);
    grp_sel   = used_pad[grp_r*PAL_GW +: PAL_GW];
    slot_pick = plc_first_zero(grp_sel);
    alloc_idx = {grp_r, slot_pick.idx};
  end

  // palette write port
  always_comb begin
    item_ok = ({1'b0, item_r.entry_index} < (PAL_IDX_W + 1)'(PAL_DEPTH));
    wr_en   = 1'b0;
    wr_used = 1'b0;
    wr_addr = item_r.entry_index[PAL_AW-1:0];
    wr_data = '0;
    if (cmd.write_entry) begin
      wr_en   = item_ok;
      wr_used = (item_r.action == ACT_UPDATE);
      wr_data = (item_r.action == ACT_UPDATE) ? item_r.color : '0;
    end else if (cmd.alloc_entry) begin
      wr_en   = grp_found_r;
      wr_used = 1'b1;
      wr_addr = PAL_AW'(alloc_idx);
      wr_data = item_r.color;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_entry) begin
      rd_data_r <= mem[pick_r[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r        <= '0;
      written_r     <= '0;
      layer_count_r <= PAL_LC_W'(1);
    end else begin
      if (wr_en) begin
        used_r[wr_addr]    <= wr_used;
        written_r[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        layer_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r.action      <= in_data.action;
      item_r.entry_index <= in_data.entry_index;
      item_r.color       <= {in_data.red, in_data.green, in_data.blue};
      pick_r             <= pick_nxt;
      pick_ok_r          <= pick_ok_nxt;
    end
    if (cmd.read_entry) begin
      rd_written_r <= written_r[pick_r[PAL_AW-1:0]];
    end
    if (cmd.find_group) begin
      grp_r       <= grp_pick.idx;
      grp_found_r <= grp_pick.found;
    end
    if (cmd.write_entry) begin
      pen_r  <= item_r.entry_index;
      fail_r <= 1'b0;
    end
    if (cmd.alloc_entry) begin
      pen_r  <= grp_found_r ? PAL_IDX_W'(alloc_idx) : '0;
      fail_r <= !grp_found_r;
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  // result assembly; unwritten entries still read their grey reset value
  always_comb begin
    out_nxt = '0;
    unique case (item_r.action)
      ACT_UPDATE, ACT_RESET, ACT_CREATE: begin
        out_nxt.pen_index     = pen_r;
        out_nxt.no_free_entry = fail_r;
      end
      ACT_CONVERT: begin
        if (pick_ok_r) begin
          out_nxt.rgb_pixel = rd_written_r ? rd_data_r : {pick_r, pick_r, pick_r};
        end
      end
      default: out_nxt = '0;
    endcase
  end

  assign out_data = out_r;

endmodule

>>> hw/rtl/plc_ctrl.sv
// ----------------------------------------------------------------------------
// plc_ctrl
// sequencer of the palette layer compositor and output valid flag
// ----------------------------------------------------------------------------
`include "palette_layer_compositor_unit_defines.svh"

module plc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  plc_pkg::plc_action_t  in_action,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output plc_pkg::plc_cmd_t     cmd
);
  import plc_pkg::*;

  plc_state_t state_r;
  plc_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_action)
            ACT_UPDATE, ACT_RESET: state_nxt = S_WRITE;
            ACT_CREATE:            state_nxt = S_FIND;
            ACT_CONVERT:           state_nxt = S_READ;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        state_nxt = S_RESULT;
      end
      S_READ: begin
        cmd.read_entry = 1'b1;
        state_nxt = S_RESULT;
      end
      S_FIND: begin
        cmd.find_group = 1'b1;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc_entry = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `PLC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r != S_IDLE, "accepted item not started")
  `PLC_ASSERT_NEXT(a_find_then_alloc, state_r == S_FIND, state_r == S_ALLOC, "search did not reach allocation")
  `PLC_ASSERT_NEXT(a_result_drains, (state_r == S_RESULT) && !out_valid_r, (state_r == S_IDLE) && out_valid_r, "free output slot not filled")
  `PLC_ASSERT_IMPL(a_single_cmd, 1'b1, $onehot0({cmd.latch, cmd.write_entry, cmd.read_entry, cmd.find_group, cmd.alloc_entry, cmd.load_out}), "overlapping datapath commands")

endmodule

>>> hw/rtl/palette_layer_compositor_unit.sv
// ----------------------------------------------------------------------------
// palette_layer_compositor_unit
// 8-bit color lookup palette with entry allocation and layer compositing
// ----------------------------------------------------------------------------
// One item is taken at a time. Update, reset entry and convert pass from transfer
// in to result ready through accept, one palette memory access and result load;
// create also passes through a group search, because the lowest free entry is
// found in two registered steps, first the lowest group of sixteen used flags
// with a free entry, then the free entry in that group. A result waits in the
// output register while the next item is taken, so a stall on the result side
// only holds back the finish of the item behind it. The palette memory has one
// write port and one registered read port; per-entry written flags make a
// never-written entry read as its grey reset value, so no clearing pass is
// needed after reset. The layer_count register is written through the cfg_
// channel, which is always ready, and should only change while the block is
// idle.
module palette_layer_compositor_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // item input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  plc_pkg::plc_in_t             in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output plc_pkg::plc_out_t            out_data,
  // layer_count register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [plc_pkg::PAL_LC_W-1:0] cfg_data
);
  import plc_pkg::*;

  plc_cmd_t cmd;

  // register writes always complete in one transfer
  assign cfg_ready = 1'b1;

  // sequencer: handshakes and datapath commands
  plc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // palette store, free-entry search, layer pick and result register
  plc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
